[rtl/sfcc_pkg.sv]
// shared types, constants and the crc-8 step for the sensor frame checker
package sfcc_pkg;

  // crc-8, polynomial 0x31, msb first
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // conversion constants, readings in signed hundredths
  localparam int unsigned FULL_SCALE  = 65535;
  localparam int unsigned TEMP_SCALE  = 17500;
  localparam int unsigned HUM_SCALE   = 12500;
  localparam int unsigned TEMP_OFFSET = 4500;
  localparam int unsigned HUM_OFFSET  = 600;

  localparam int unsigned WORD_W      = 16;
  localparam int unsigned CENTI_W     = 15;
  localparam int unsigned TEMP_PROD_W = $clog2(FULL_SCALE * TEMP_SCALE + 1);
  localparam int unsigned HUM_PROD_W  = $clog2(FULL_SCALE * HUM_SCALE + 1);
  localparam int unsigned REM_W       = WORD_W + 1;

  // entries in the queue between front and back
  localparam int unsigned FIFO_DEPTH = 2;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_FIRST_BAD  = 2'd1,
    STATUS_SECOND_BAD = 2'd2
  } status_e;

  // one checked frame handed from front to back
  typedef struct packed {
    status_e             status;
    logic [WORD_W-1:0]   word_first;
    logic [WORD_W-1:0]   word_second;
  } frame_rec_t;

  // one byte through the crc register, eight shift steps
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[rtl/sfcc_if.sv]
// valid/ready channels for reply bytes and for converted results
interface sfcc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface sfcc_res_if
  import sfcc_pkg::*;
;
  logic                       valid;
  logic                       ready;
  status_e                    status;
  logic [WORD_W-1:0]          word_first;
  logic [WORD_W-1:0]          word_second;
  logic signed [CENTI_W-1:0]  temp_centi;
  logic signed [CENTI_W-1:0]  hum_centi;

  modport source (output valid, output status, output word_first, output word_second,
                  output temp_centi, output hum_centi, input ready);
  modport sink   (input valid, input status, input word_first, input word_second,
                  input temp_centi, input hum_centi, output ready);
endinterface

[rtl/sensor_frame_crc_check_convert.sv]
// top level: sensor reply crc checker and temperature / humidity converter
// Takes one reply byte per cycle on byte_i (valid/ready) and, on the sixth byte
// of each frame, produces one result on res_o. Each of the two 16-bit words is
// checked against its CRC-8 byte (poly 0x31, init 0xFF); a bad first word
// reports status 1, a bad second word status 2, and either clears all data
// fields. frame_start on a byte restarts framing at that byte and drops any
// partial frame. The front end framing and CRC logic handles a byte every
// cycle while the queue has room; completed frames go through a FIFO_DEPTH-entry
// queue into a two-stage conversion pipeline (constant multiply into the
// product register, then divide-by-65535 with one correction step into the
// output register) that drives res_o. byte_i.ready drops only while the
// queue is full; results can be held off on res_o without stalling bytes until
// then. No configuration registers and no clearing pass after reset.
module sensor_frame_crc_check_convert
  import sfcc_pkg::*;
#(
  parameter int unsigned FifoDepth = FIFO_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sfcc_byte_if.sink  byte_i,
  sfcc_res_if.source res_o
);

  logic       push_valid, push_ready;
  frame_rec_t push_rec;
  logic       pop_valid, pop_ready;
  frame_rec_t pop_rec;

  // framing and crc check
  sfcc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (byte_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_rec_o   (push_rec)
  );

  // decoupling queue
  sfcc_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_rec_i   (push_rec),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_rec_o    (pop_rec)
  );

  // conversion and result register
  sfcc_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_rec_i   (pop_rec),
    .res_o       (res_o)
  );

endmodule

[rtl/sfcc_front.sv]
// byte framing, crc check and word assembly; pushes one record per frame
module sfcc_front
  import sfcc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  sfcc_byte_if.sink         byte_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output frame_rec_t        push_rec_o
);

  typedef enum logic [2:0] {
    POS_A_HI  = 3'd0,
    POS_A_LO  = 3'd1,
    POS_A_CRC = 3'd2,
    POS_B_HI  = 3'd3,
    POS_B_LO  = 3'd4,
    POS_B_CRC = 3'd5
  } pos_e;

  pos_e        pos_q, pos_d, pos_eff;
  logic [7:0]  crc_q, crc_d, crc_base, crc_next;
  logic [15:0] first_word_q, first_word_d;
  logic        first_good_q, first_good_d;
  logic [7:0]  second_hi_q, second_hi_d;
  logic [7:0]  second_lo_q, second_lo_d;
  logic        take;
  status_e     status;

  assign byte_i.ready = push_ready_i;
  assign take         = byte_i.valid && byte_i.ready;

  // frame_start forces the first position, each word restarts the crc
  assign pos_eff  = byte_i.frame_start ? POS_A_HI : pos_q;
  assign crc_base = (pos_eff == POS_A_HI || pos_eff == POS_B_HI) ? CRC_INIT : crc_q;
  assign crc_next = crc8_byte(crc_base, byte_i.rx_byte);

  // status of a completed frame, first word checked first
  always_comb begin
    if (!first_good_q) begin
      status = STATUS_FIRST_BAD;
    end else if (crc_q != byte_i.rx_byte) begin
      status = STATUS_SECOND_BAD;
    end else begin
      status = STATUS_OK;
    end
  end

  // record for the back end, words cleared on a crc failure
  always_comb begin
    push_valid_o           = take && (pos_eff == POS_B_CRC);
    push_rec_o.status      = status;
    push_rec_o.word_first  = (status == STATUS_OK) ? first_word_q : '0;
    push_rec_o.word_second = (status == STATUS_OK) ? {second_hi_q, second_lo_q} : '0;
  end

  // next state per byte position
  always_comb begin
    pos_d        = pos_q;
    crc_d        = crc_q;
    first_word_d = first_word_q;
    first_good_d = first_good_q;
    second_hi_d  = second_hi_q;
    second_lo_d  = second_lo_q;
    if (take) begin
      unique case (pos_eff)
        POS_A_HI: begin
          crc_d        = crc_next;
          first_word_d = {byte_i.rx_byte, 8'h00};
          pos_d        = POS_A_LO;
        end
        POS_A_LO: begin
          crc_d        = crc_next;
          first_word_d = {first_word_q[15:8], byte_i.rx_byte};
          pos_d        = POS_A_CRC;
        end
        POS_A_CRC: begin
          first_good_d = (crc_q == byte_i.rx_byte);
          pos_d        = POS_B_HI;
        end
        POS_B_HI: begin
          crc_d       = crc_next;
          second_hi_d = byte_i.rx_byte;
          pos_d       = POS_B_LO;
        end
        POS_B_LO: begin
          crc_d       = crc_next;
          second_lo_d = byte_i.rx_byte;
          pos_d       = POS_B_CRC;
        end
        POS_B_CRC: begin
          crc_d = CRC_INIT;
          pos_d = POS_A_HI;
        end
        default: begin
          pos_d = POS_A_HI;
        end
      endcase
    end
  end

  // framing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= POS_A_HI;
      crc_q        <= CRC_INIT;
      first_word_q <= '0;
      first_good_q <= 1'b0;
      second_hi_q  <= '0;
      second_lo_q  <= '0;
    end else begin
      pos_q        <= pos_d;
      crc_q        <= crc_d;
      first_word_q <= first_word_d;
      first_good_q <= first_good_d;
      second_hi_q  <= second_hi_d;
      second_lo_q  <= second_lo_d;
    end
  end

  // a record leaves only with the last byte of a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid_o |-> take && pos_d == POS_A_HI && crc_d == CRC_INIT)
    else $error("frame record pushed outside the last byte");

endmodule

[rtl/sfcc_fifo.sv]
// short record queue between the framing front and the conversion back
module sfcc_fifo
  import sfcc_pkg::*;
#(
  parameter int unsigned Depth = FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_valid_i,
  output logic        push_ready_o,
  input  frame_rec_t  push_rec_i,
  output logic        pop_valid_o,
  input  logic        pop_ready_i,
  output frame_rec_t  pop_rec_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  frame_rec_t          mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;
  logic                push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_rec_o    = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_rec_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(Depth))
    else $error("queue fill count above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");

endmodule

[rtl/sfcc_conv.sv]
// two-stage scaling of the raw words into signed hundredths with output register
module sfcc_conv
  import sfcc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pop_valid_i,
  output logic        pop_ready_o,
  input  frame_rec_t  pop_rec_i,
  sfcc_res_if.source  res_o
);

  localparam int unsigned TQW = TEMP_PROD_W - WORD_W;
  localparam int unsigned HQW = HUM_PROD_W - WORD_W;

  logic                       s1_valid_q, out_valid_q;
  frame_rec_t                 s1_rec_q;
  logic [TEMP_PROD_W-1:0]     temp_prod_q;
  logic [HUM_PROD_W-1:0]      hum_prod_q;
  logic                       adv1, adv2;

  logic [TQW-1:0]             temp_q0;
  logic [HQW-1:0]             hum_q0;
  logic [REM_W-1:0]           temp_rem, hum_rem;
  logic [CENTI_W-1:0]         temp_quo, hum_quo;
  logic signed [CENTI_W-1:0]  temp_val, hum_val;

  status_e                    status_q;
  logic [WORD_W-1:0]          word_first_q, word_second_q;
  logic signed [CENTI_W-1:0]  temp_centi_q, hum_centi_q;

  // stall control: output register, then product register
  assign adv2        = !out_valid_q || res_o.ready;
  assign adv1        = !s1_valid_q || adv2;
  assign pop_ready_o = adv1;

  // divide by 65535: quotient estimate from the high bits, one correction step
  always_comb begin
    temp_q0  = temp_prod_q[TEMP_PROD_W-1:WORD_W];
    hum_q0   = hum_prod_q[HUM_PROD_W-1:WORD_W];
    temp_rem = REM_W'(temp_prod_q[WORD_W-1:0]) + REM_W'(temp_q0);
    hum_rem  = REM_W'(hum_prod_q[WORD_W-1:0]) + REM_W'(hum_q0);
    temp_quo = CENTI_W'(temp_q0) + CENTI_W'(temp_rem >= REM_W'(FULL_SCALE));
    hum_quo  = CENTI_W'(hum_q0) + CENTI_W'(hum_rem >= REM_W'(FULL_SCALE));
    temp_val = signed'(temp_quo - CENTI_W'(TEMP_OFFSET));
    hum_val  = signed'(hum_quo - CENTI_W'(HUM_OFFSET));
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid_q <= pop_valid_i;
      end
      if (adv2) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // stage one: constant products
  always_ff @(posedge clk_i) begin
    if (adv1 && pop_valid_i) begin
      s1_rec_q    <= pop_rec_i;
      temp_prod_q <= TEMP_PROD_W'(pop_rec_i.word_first) * TEMP_PROD_W'(TEMP_SCALE);
      hum_prod_q  <= HUM_PROD_W'(pop_rec_i.word_second) * HUM_PROD_W'(HUM_SCALE);
    end
  end

  // stage two: quotient, offset, zeroing of failed frames
  always_ff @(posedge clk_i) begin
    if (adv2 && s1_valid_q) begin
      status_q      <= s1_rec_q.status;
      word_first_q  <= s1_rec_q.word_first;
      word_second_q <= s1_rec_q.word_second;
      temp_centi_q  <= (s1_rec_q.status == STATUS_OK) ? temp_val : '0;
      hum_centi_q   <= (s1_rec_q.status == STATUS_OK) ? hum_val : '0;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.status      = status_q;
  assign res_o.word_first  = word_first_q;
  assign res_o.word_second = word_second_q;
  assign res_o.temp_centi  = temp_centi_q;
  assign res_o.hum_centi   = hum_centi_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.status != STATUS_OK) |->
      (res_o.word_first == '0 && res_o.word_second == '0 &&
       res_o.temp_centi == '0 && res_o.hum_centi == '0))
    else $error("failed frame carries nonzero fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.status == STATUS_OK) |->
      (res_o.temp_centi >= -15'sd4500 && res_o.temp_centi <= 15'sd13000 &&
       res_o.hum_centi >= -15'sd600 && res_o.hum_centi <= 15'sd11900))
    else $error("converted reading out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv2) |=> s1_valid_q)
    else $error("product stage lost an entry under stall");

endmodule
